>>> design/bdc_pkg.sv
package bdc_pkg;

	localparam int MAX_POINTS_DEF  = 16;
	localparam int COORD_WIDTH_DEF = 16;

	localparam int FIELD_WIDTH = 16;
	localparam int T_WIDTH     = 17;
	localparam int SEG_WIDTH   = 6;

	localparam logic [T_WIDTH-1:0]   T_ONE     = 17'h10000;
	localparam logic [SEG_WIDTH-1:0] SEG_RESET = 6'd20;

	// Start value of the countdown between interpolation levels. The wait lets the lerp pipeline
	// write back everything the next level reads.
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_EVAL   = 2'd1;
	localparam logic [1:0] CMD_SWEEP  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic       rd_en;
		logic       rd_src_work;
		logic       rd_first;
		logic       rd_cap;
		logic       ctrl_we;
		logic       ctrl_wsel_new;
		logic       load_pt;
		logic       load_t;
		logic       sweep_init;
		logic       t_step;
		logic       load_out;
		logic       out_use_res;
		logic [1:0] out_status;
		logic       out_last;
	} ctl_t;

	typedef struct packed {
		logic                 ins_lt;
		logic                 out_busy;
		logic                 div_busy;
		logic [SEG_WIDTH-1:0] seg_eff;
	} stat_t;

endpackage

>>> design/bdc_div.sv
module bdc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bdc_pkg::SEG_WIDTH-1:0]   divisor,
	output logic                            busy,
	output logic [bdc_pkg::T_WIDTH-1:0]     quo,
	output logic [bdc_pkg::SEG_WIDTH-1:0]   rem
);

	// Restoring division of one full turn of t by the segment count, one bit per cycle.
	logic                            busy_q;
	logic [4:0]                      cnt_q;
	logic [bdc_pkg::T_WIDTH-1:0]     quo_q;
	logic [bdc_pkg::SEG_WIDTH-1:0]   rem_q;
	logic [bdc_pkg::SEG_WIDTH:0]     trial;
	logic                            qbit;

	always_comb begin
		trial = {rem_q, bdc_pkg::T_ONE[cnt_q]};
		qbit  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(bdc_pkg::T_WIDTH - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? bdc_pkg::SEG_WIDTH'(trial - {1'b0, divisor})
			              : trial[bdc_pkg::SEG_WIDTH-1:0];
			quo_q <= {quo_q[bdc_pkg::T_WIDTH-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> design/bdc_datapath.sv
module bdc_datapath #(
	parameter int MAX_POINTS  = bdc_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = bdc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bdc_pkg::ctl_t                          ctl,
	input  logic [$clog2(MAX_POINTS)-1:0]          rd_addr,
	input  logic [$clog2(MAX_POINTS)-1:0]          ctrl_waddr,
	output bdc_pkg::stat_t                         stat,
	input  logic signed [bdc_pkg::FIELD_WIDTH-1:0] point_x,
	input  logic signed [bdc_pkg::FIELD_WIDTH-1:0] point_y,
	input  logic [bdc_pkg::T_WIDTH-1:0]            param_t,
	input  logic                                   cfg_we,
	input  logic [bdc_pkg::SEG_WIDTH-1:0]          segment_count,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic signed [bdc_pkg::FIELD_WIDTH-1:0] curve_x,
	output logic signed [bdc_pkg::FIELD_WIDTH-1:0] curve_y,
	output logic [1:0]                             status,
	output logic                                   last
);

	localparam int IDXW = $clog2(MAX_POINTS);
	localparam int CW   = COORD_WIDTH;
	localparam int PW   = CW + 1 + bdc_pkg::T_WIDTH + 1;

	logic signed [CW-1:0] cx_mem [MAX_POINTS];
	logic signed [CW-1:0] cy_mem [MAX_POINTS];
	logic signed [CW-1:0] wx_mem [MAX_POINTS];
	logic signed [CW-1:0] wy_mem [MAX_POINTS];

	logic signed [CW-1:0] cx_rd_q, cy_rd_q, wx_rd_q, wy_rd_q;
	logic signed [CW-1:0] newx_q, newy_q;
	logic signed [CW-1:0] prevx_q, prevy_q;
	logic signed [CW-1:0] resx_q, resy_q;
	logic signed [CW-1:0] dsel_x, dsel_y;

	logic                 v_s1, first_s1, cap_s1, src_s1;
	logic [IDXW-1:0]      addr_s1;
	logic                 v_s2;
	logic [IDXW-1:0]      waddr_s2;
	logic signed [CW-1:0] ax_s2, ay_s2;
	logic signed [CW:0]   dx_s2, dy_s2;
	logic                 v_s3;
	logic [IDXW-1:0]      waddr_s3;
	logic signed [CW-1:0] ax_s3, ay_s3;
	logic signed [PW-1:0] px_s3, py_s3;
	logic [CW-1:0]        lx, ly;

	logic [bdc_pkg::T_WIDTH-1:0]   t_q;
	logic [bdc_pkg::SEG_WIDTH-1:0] r_q;
	logic [bdc_pkg::SEG_WIDTH-1:0] seg_q;
	logic [bdc_pkg::SEG_WIDTH-1:0] seg_eff;
	logic [bdc_pkg::SEG_WIDTH:0]   r_sum;
	logic                          div_busy;
	logic [bdc_pkg::T_WIDTH-1:0]   div_quo;
	logic [bdc_pkg::SEG_WIDTH-1:0] div_rem;

	logic                          out_valid_q;

	bdc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.sweep_init),
		.divisor (seg_eff),
		.busy    (div_busy),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	assign seg_eff = (seg_q == '0) ? bdc_pkg::SEG_WIDTH'(1) : seg_q;
	assign dsel_x  = src_s1 ? wx_rd_q : cx_rd_q;
	assign dsel_y  = src_s1 ? wy_rd_q : cy_rd_q;
	assign lx      = ax_s3 + px_s3[CW+15:16];
	assign ly      = ay_s3 + py_s3[CW+15:16];
	assign r_sum   = {1'b0, r_q} + {1'b0, div_rem};

	// Memories: control points and the de Casteljau working row.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			cx_rd_q <= cx_mem[rd_addr];
			cy_rd_q <= cy_mem[rd_addr];
			wx_rd_q <= wx_mem[rd_addr];
			wy_rd_q <= wy_mem[rd_addr];
		end
		if (ctl.ctrl_we) begin
			cx_mem[ctrl_waddr] <= ctl.ctrl_wsel_new ? newx_q : cx_rd_q;
			cy_mem[ctrl_waddr] <= ctl.ctrl_wsel_new ? newy_q : cy_rd_q;
		end
		if (v_s3) begin
			wx_mem[waddr_s3] <= lx;
			wy_mem[waddr_s3] <= ly;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			seg_q <= bdc_pkg::SEG_RESET;
		end else begin
			v_s1 <= ctl.rd_en && !ctl.ctrl_we;
			v_s2 <= v_s1 && !first_s1 && !cap_s1;
			v_s3 <= v_s2;
			if (cfg_we) begin
				seg_q <= segment_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl.rd_first;
		cap_s1   <= ctl.rd_cap;
		src_s1   <= ctl.rd_src_work;
		addr_s1  <= rd_addr;
		if (v_s1) begin
			prevx_q <= dsel_x;
			prevy_q <= dsel_y;
		end
		if (v_s1 && cap_s1) begin
			resx_q <= dsel_x;
			resy_q <= dsel_y;
		end
		waddr_s2 <= addr_s1 - 1'b1;
		ax_s2    <= prevx_q;
		ay_s2    <= prevy_q;
		dx_s2    <= {dsel_x[CW-1], dsel_x} - {prevx_q[CW-1], prevx_q};
		dy_s2    <= {dsel_y[CW-1], dsel_y} - {prevy_q[CW-1], prevy_q};
		waddr_s3 <= waddr_s2;
		ax_s3    <= ax_s2;
		ay_s3    <= ay_s2;
		px_s3    <= dx_s2 * $signed({1'b0, t_q});
		py_s3    <= dy_s2 * $signed({1'b0, t_q});
	end

	// Point to insert, and the curve parameter for evaluate and sweep.
	always_ff @(posedge clk) begin
		if (ctl.load_pt) begin
			newx_q <= CW'(point_x);
			newy_q <= CW'(point_y);
		end
		if (ctl.load_t) begin
			t_q <= (param_t > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE : param_t;
		end else if (ctl.sweep_init) begin
			t_q <= '0;
			r_q <= '0;
		end else if (ctl.t_step) begin
			if (r_sum >= {1'b0, seg_eff}) begin
				r_q <= bdc_pkg::SEG_WIDTH'(r_sum - {1'b0, seg_eff});
				t_q <= t_q + div_quo + 1'b1;
			end else begin
				r_q <= r_sum[bdc_pkg::SEG_WIDTH-1:0];
				t_q <= t_q + div_quo;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			curve_x <= ctl.out_use_res ? bdc_pkg::FIELD_WIDTH'(resx_q) : '0;
			curve_y <= ctl.out_use_res ? bdc_pkg::FIELD_WIDTH'(resy_q) : '0;
			status  <= ctl.out_status;
			last    <= ctl.out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.ins_lt   = (cx_rd_q < newx_q);
	assign stat.out_busy = out_valid_q && !out_ready;
	assign stat.div_busy = div_busy;
	assign stat.seg_eff  = seg_eff;

endmodule

>>> design/bdc_ctrl.sv
module bdc_ctrl #(
	parameter int MAX_POINTS = bdc_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	output bdc_pkg::ctl_t                 ctl,
	output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	output logic [$clog2(MAX_POINTS)-1:0] ctrl_waddr,
	input  bdc_pkg::stat_t                stat
);

	localparam int IDXW = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_INS_RD  = 9'b000000010,
		S_INS_CMP = 9'b000000100,
		S_DIV     = 9'b000001000,
		S_LVL     = 9'b000010000,
		S_DRAIN   = 9'b000100000,
		S_CAPT    = 9'b001000000,
		S_CWAIT   = 9'b010000000,
		S_EMIT    = 9'b100000000
	} state_t;

	state_t                        state_q;
	logic [CNTW-1:0]               pcount_q;
	logic [CNTW-1:0]               i_q;
	logic [CNTW-1:0]               m_q;
	logic [IDXW-1:0]               k_q;
	logic [1:0]                    dr_q;
	logic [bdc_pkg::SEG_WIDTH-1:0] j_q;
	logic                          sweep_q;
	logic                          em_res_q;
	logic [1:0]                    em_st_q;
	logic                          accept;
	logic                          full;
	logic                          more;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (pcount_q == CNTW'(MAX_POINTS));
	assign more     = sweep_q && (j_q != stat.seg_eff);

	always_comb begin
		ctl        = '0;
		rd_addr    = '0;
		ctrl_waddr = '0;
		case (state_q)
			S_IDLE: begin
				ctl.load_pt    = accept && (cmd == bdc_pkg::CMD_INSERT);
				ctl.load_t     = accept && (cmd == bdc_pkg::CMD_EVAL);
				ctl.sweep_init = accept && (cmd == bdc_pkg::CMD_SWEEP) && (pcount_q != '0);
			end
			S_INS_RD: begin
				if (i_q == '0) begin
					ctl.ctrl_we       = 1'b1;
					ctl.ctrl_wsel_new = 1'b1;
				end else begin
					ctl.rd_en = 1'b1;
					rd_addr   = IDXW'(i_q - 1'b1);
				end
			end
			S_INS_CMP: begin
				ctl.ctrl_we       = 1'b1;
				ctl.ctrl_wsel_new = stat.ins_lt;
				ctrl_waddr        = IDXW'(i_q);
			end
			S_LVL: begin
				ctl.rd_en       = 1'b1;
				ctl.rd_src_work = (m_q != pcount_q);
				ctl.rd_first    = (k_q == '0);
				rd_addr         = k_q;
			end
			S_CAPT: begin
				ctl.rd_en       = 1'b1;
				ctl.rd_cap      = 1'b1;
				ctl.rd_src_work = (pcount_q != CNTW'(1));
			end
			S_EMIT: begin
				ctl.load_out    = !stat.out_busy;
				ctl.out_use_res = em_res_q;
				ctl.out_status  = em_st_q;
				ctl.out_last    = !more;
				ctl.t_step      = !stat.out_busy && more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pcount_q <= '0;
			i_q      <= '0;
			m_q      <= '0;
			k_q      <= '0;
			dr_q     <= '0;
			j_q      <= '0;
			sweep_q  <= 1'b0;
			em_res_q <= 1'b0;
			em_st_q  <= bdc_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sweep_q  <= 1'b0;
						em_res_q <= 1'b0;
						em_st_q  <= bdc_pkg::ST_OK;
						j_q      <= '0;
						case (cmd)
							bdc_pkg::CMD_INSERT: begin
								if (full) begin
									em_st_q <= bdc_pkg::ST_FULL;
									state_q <= S_EMIT;
								end else begin
									i_q     <= pcount_q;
									state_q <= S_INS_RD;
								end
							end
							bdc_pkg::CMD_EVAL, bdc_pkg::CMD_SWEEP: begin
								if (pcount_q == '0) begin
									em_st_q <= bdc_pkg::ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									em_res_q <= 1'b1;
									sweep_q  <= (cmd == bdc_pkg::CMD_SWEEP);
									m_q      <= pcount_q;
									k_q      <= '0;
									if (cmd == bdc_pkg::CMD_SWEEP) begin
										state_q <= S_DIV;
									end else if (pcount_q == CNTW'(1)) begin
										state_q <= S_CAPT;
									end else begin
										state_q <= S_LVL;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						pcount_q <= pcount_q + 1'b1;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (stat.ins_lt) begin
						pcount_q <= pcount_q + 1'b1;
						state_q  <= S_EMIT;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_INS_RD;
					end
				end
				S_DIV: begin
					if (!stat.div_busy) begin
						state_q <= (pcount_q == CNTW'(1)) ? S_CAPT : S_LVL;
					end
				end
				S_LVL: begin
					if (CNTW'(k_q) == m_q - 1'b1) begin
						k_q     <= '0;
						m_q     <= m_q - 1'b1;
						dr_q    <= bdc_pkg::DRAIN_LAST;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (dr_q == '0) begin
						state_q <= (m_q == CNTW'(1)) ? S_CAPT : S_LVL;
					end else begin
						dr_q <= dr_q - 1'b1;
					end
				end
				S_CAPT: begin
					state_q <= S_CWAIT;
				end
				S_CWAIT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!stat.out_busy) begin
						if (more) begin
							j_q     <= j_q + 1'b1;
							m_q     <= pcount_q;
							k_q     <= '0;
							state_q <= (pcount_q == CNTW'(1)) ? S_CAPT : S_LVL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= CNTW'(MAX_POINTS))
		else $error("control point count above capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !stat.out_busy)
		else $error("output register overwritten while its request waits");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP && stat.ins_lt) |=> pcount_q == CNTW'($past(pcount_q) + 1'b1))
		else $error("insert did not raise the point count");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy)
		else $error("step divider still busy while idle");

endmodule

>>> design/bezier_de_casteljau_eval_top.sv
// Bezier curve evaluator. The block keeps up to MAX_POINTS control points, sorted by x, and
// evaluates their Bezier curve by de Casteljau's repeated linear interpolation in signed Q2.14
// with t in Q1.16. An insert request (cmd 0) places a point before the first stored point whose
// x is not less and returns one response with zero coordinates and status ok, or status full if
// the store already holds MAX_POINTS points. An evaluate request (cmd 1) saturates t to 1.0 and
// returns one curve point; a sweep request (cmd 2) returns segment_count+1 points at
// t = floor(i*65536/segment_count), with last set on the final one. With no points stored,
// evaluate and sweep return one response with status empty; cmd 3 is dropped silently. The
// segment count is written through the cfg channel (a value of 0 acts as 1) and must only be
// written while the block is idle. One x lerp and one y lerp stream through a single read
// port of the working memory, one interpolation per cycle, and at the end of each level wait
// for their pipeline to write back before the next level reads. A sweep first runs the step
// divider. An insert moves each stored point whose x is not less up by one place. A new
// request is taken as soon as the last response of the previous one sits in the output
// register.
module bezier_de_casteljau_eval_top #(
	parameter int MAX_POINTS  = bdc_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = bdc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             cmd,
	input  logic signed [bdc_pkg::FIELD_WIDTH-1:0] point_x,
	input  logic signed [bdc_pkg::FIELD_WIDTH-1:0] point_y,
	input  logic [bdc_pkg::T_WIDTH-1:0]            param_t,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [bdc_pkg::FIELD_WIDTH-1:0] curve_x,
	output logic signed [bdc_pkg::FIELD_WIDTH-1:0] curve_y,
	output logic [1:0]                             status,
	output logic                                   last,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bdc_pkg::SEG_WIDTH-1:0]          segment_count
);

	localparam int IDXW = $clog2(MAX_POINTS);

	bdc_pkg::ctl_t   ctl;
	bdc_pkg::stat_t  stat;
	logic [IDXW-1:0] rd_addr;
	logic [IDXW-1:0] ctrl_waddr;

	// The segment count register is always ready to take a write.
	assign cfg_ready = 1'b1;

	// The controller sequences inserts, interpolation levels and responses.
	bdc_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.ctrl_waddr (ctrl_waddr),
		.stat       (stat)
	);

	// The datapath holds the point store, the working row, the lerp pipeline and the output.
	bdc_datapath #(
		.MAX_POINTS  (MAX_POINTS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.rd_addr       (rd_addr),
		.ctrl_waddr    (ctrl_waddr),
		.stat          (stat),
		.point_x       (point_x),
		.point_y       (point_y),
		.param_t       (param_t),
		.cfg_we        (cfg_valid && cfg_ready),
		.segment_count (segment_count),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.curve_x       (curve_x),
		.curve_y       (curve_y),
		.status        (status),
		.last          (last)
	);

endmodule
